// ===== rtl/core/srse_pkg.sv =====
package srse_pkg;

  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned N_W          = 9;
  localparam int unsigned SY_W         = 33;
  localparam int unsigned SXY_W        = 42;
  localparam int unsigned SYY_W        = 56;
  localparam int unsigned RES_W        = 32;
  localparam int unsigned WIDE_W       = 128;
  localparam int unsigned MB_W         = 64;
  localparam int unsigned DEN_W        = 40;
  localparam int unsigned SQ_W         = 18;
  localparam logic [N_W-1:0] WINDOW_RESET = 9'd20;
  localparam logic [N_W-1:0] WINDOW_MIN   = 9'd2;

  typedef struct packed {
    logic [N_W-1:0]           n;
    logic signed [SY_W-1:0]   sy;
    logic signed [SXY_W-1:0]  sxy;
    logic signed [SYY_W-1:0]  syy;
  } srse_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] result;
  } srse_rsp_t;

endpackage

// ===== rtl/core/srse_if.sv =====
interface srse_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [srse_pkg::SAMPLE_W-1:0]     sample;
  logic                                     restart;
  modport source (output valid, sample, restart, input ready);
  modport sink (input valid, sample, restart, output ready);
endinterface

interface srse_out_if;
  logic                          valid;
  logic                          ready;
  logic [srse_pkg::RES_W-1:0]    std_err;
  modport source (output valid, std_err, input ready);
  modport sink (input valid, std_err, output ready);
endinterface

interface srse_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [srse_pkg::N_W-1:0]      window_length;
  modport source (output valid, window_length, input ready);
  modport sink (input valid, window_length, output ready);
endinterface

// ===== rtl/core/srse_ring.sv =====
module srse_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [AW-1:0]                         waddr_i,
  input  logic signed [srse_pkg::SAMPLE_W-1:0]  wdata_i,
  input  logic                                  re_i,
  input  logic [AW-1:0]                         raddr_i,
  output logic signed [srse_pkg::SAMPLE_W-1:0]  rdata_o
);
  import srse_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/srse_solver.sv =====
module srse_solver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  srse_pkg::srse_req_t req_i,
  output srse_pkg::srse_rsp_t rsp_o
);
  import srse_pkg::*;

  localparam int unsigned CW = $clog2(WIDE_W);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_SUB, ST_CHK, ST_DIV, ST_ROOT_INIT, ST_ROOT
  } state_e;

  state_e                    state_q;
  logic signed [WIDE_W-1:0]  acc_q, mca_q, a_q, p4_q;
  logic [WIDE_W-1:0]         num_q;
  logic [MB_W-1:0]           mb_q;
  logic [6:0]                mcnt_q;
  logic [SQ_W-1:0]           n2_q, nn1_q;
  logic [DEN_W-1:0]          den_q, rem_q;
  logic [CW-1:0]             cnt_q;
  logic [63:0]               sv_q, sres_q, sbit_q;
  logic [RES_W-1:0]          res_q;
  logic                      done_q;

  logic signed [WIDE_W-1:0]  acc_nx, t_w;
  logic [DEN_W-1:0]          trial;
  logic                      div_ge, root_ge;
  logic [63:0]               root_sum, sres_nx;
  logic [SQ_W-1:0]           n2_w;

  assign acc_nx = mb_q[0] ? ((mcnt_q == 7'd1) ? acc_q - mca_q : acc_q + mca_q) : acc_q;
  assign t_w    = (WIDE_W'(req_i.sxy) <<< 1) - acc_q;
  assign trial  = {rem_q[DEN_W-2:0], num_q[WIDE_W-1]};
  assign div_ge = trial >= den_q;
  assign root_sum = sres_q + sbit_q;
  assign root_ge  = sv_q >= root_sum;
  assign sres_nx  = root_ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
  assign n2_w     = SQ_W'(req_i.n * req_i.n);

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      mcnt_q  <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (mcnt_q != 7'd0) begin
        acc_q  <= acc_nx;
        mca_q  <= mca_q <<< 1;
        mb_q   <= mb_q >> 1;
        mcnt_q <= mcnt_q - 7'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            n2_q   <= n2_w;
            nn1_q  <= n2_w - SQ_W'(1);
            acc_q  <= '0;
            mca_q  <= WIDE_W'(req_i.syy);
            mb_q   <= MB_W'(req_i.n);
            mcnt_q <= 7'd10;
            state_q <= ST_M1;
          end
        end
        ST_M1: begin
          den_q <= DEN_W'(n2_q * nn1_q);
          if (mcnt_q == 7'd0) begin
            a_q    <= acc_q;
            acc_q  <= '0;
            mca_q  <= WIDE_W'(req_i.sy);
            mb_q   <= MB_W'(req_i.sy);
            mcnt_q <= 7'd33;
            state_q <= ST_M2;
          end
        end
        ST_M2: begin
          if (mcnt_q == 7'd0) begin
            a_q    <= a_q - acc_q;
            acc_q  <= '0;
            mca_q  <= WIDE_W'(req_i.sy);
            mb_q   <= MB_W'(req_i.n - N_W'(1));
            mcnt_q <= 7'd10;
            state_q <= ST_M3;
          end
        end
        ST_M3: begin
          if (mcnt_q == 7'd0) begin
            acc_q  <= '0;
            mca_q  <= t_w;
            mb_q   <= t_w[MB_W-1:0];
            mcnt_q <= 7'd48;
            state_q <= ST_M4;
          end
        end
        ST_M4: begin
          if (mcnt_q == 7'd0) begin
            p4_q   <= acc_q;
            acc_q  <= '0;
            mca_q  <= a_q;
            mb_q   <= MB_W'(nn1_q);
            mcnt_q <= 7'd20;
            state_q <= ST_M5;
          end
        end
        ST_M5: begin
          if (mcnt_q == 7'd0) begin
            num_q   <= acc_q - p4_q;
            state_q <= ST_SUB;
          end
        end
        ST_SUB: begin
          num_q   <= num_q - (p4_q <<< 1);
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (num_q[WIDE_W-1]) begin
            res_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            num_q   <= num_q << 16;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? trial - den_q : trial;
          num_q <= {num_q[WIDE_W-2:0], div_ge};
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(WIDE_W - 1)) begin
            state_q <= ST_ROOT_INIT;
          end
        end
        ST_ROOT_INIT: begin
          if (|num_q[WIDE_W-1:64]) begin
            res_q   <= '1;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            sv_q    <= num_q[63:0];
            sres_q  <= '0;
            sbit_q  <= 64'd1 << 62;
            cnt_q   <= '0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_ge) begin
            sv_q <= sv_q - root_sum;
          end
          sres_q <= sres_nx;
          sbit_q <= sbit_q >> 2;
          cnt_q  <= cnt_q + CW'(1);
          if (cnt_q == CW'(31)) begin
            res_q   <= sres_nx[RES_W-1:0];
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sliding_regression_std_error_core.sv =====
// Rolling least-squares standard error over the last window_length samples (2 to MAX_WINDOW,
// default 20). Each beat on in_i carries a signed 24-bit sample; restart empties the window
// first, as does any write on cfg_i. Once the window is full every sample yields one beat on
// out_o: the root mean squared residual about the fitted line, unsigned Q24.8, rounded down.
// Samples live in a ring memory with a registered read port; each sample is first registered
// with its products, then the running sums update. The residual closed form is then evaluated
// by one shared bit-serial multiplier (five products), a 128-step restoring divider and a
// 32-step integer root; an item that gives no result returns to idle once its sums update.
// One item is in work at a time; the output register lets a finished result wait
// while the next sample is taken. A configuration beat is taken only while idle and goes
// ahead of a waiting sample.
module sliding_regression_std_error_core #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srse_in_if.sink     in_i,
  srse_out_if.source  out_o,
  srse_cfg_if.sink    cfg_i
);
  import srse_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned OW = AW + N_W + 1;

  typedef enum logic [2:0] {S_IDLE, S_UPDATE, S_START, S_WAIT, S_EMIT} state_e;

  state_e                     state_q;
  logic [N_W-1:0]             n_q, fill_q, cfg_n;
  logic [AW-1:0]              wp_q, old_idx;
  logic signed [SY_W-1:0]     sy_q;
  logic signed [SXY_W-1:0]    sxy_q;
  logic signed [SYY_W-1:0]    syy_q;
  logic signed [SAMPLE_W-1:0] y_q, rdata;
  logic signed [47:0]         yy_q, oo;
  logic signed [N_W+SAMPLE_W:0] ym_q;
  logic                       full_q, out_valid_q;
  logic [RES_W-1:0]           out_data_q;
  logic [N_W-1:0]             weight, fill_inc;
  logic [OW-1:0]              idx_tmp;
  logic                       accept, upd, emit;
  srse_req_t                  req;
  srse_rsp_t                  rsp;

  assign in_i.ready          = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_i.ready         = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.std_err       = out_data_q;
  assign accept = in_i.valid && in_i.ready;
  assign upd    = (state_q == S_UPDATE);

  assign idx_tmp = OW'(wp_q) + OW'(MAX_WINDOW) - OW'(n_q);
  assign old_idx = (idx_tmp >= OW'(MAX_WINDOW)) ? AW'(idx_tmp - OW'(MAX_WINDOW)) : AW'(idx_tmp);
  assign weight  = in_i.restart ? '0 : ((fill_q >= n_q) ? n_q - N_W'(1) : fill_q);
  assign oo       = rdata * rdata;
  assign fill_inc = fill_q + N_W'(1);
  assign emit     = full_q || (fill_inc >= n_q);

  always_comb begin
    cfg_n = cfg_i.window_length;
    if (cfg_n < WINDOW_MIN) begin
      cfg_n = WINDOW_MIN;
    end
    if (32'(cfg_i.window_length) > 32'(MAX_WINDOW)) begin
      cfg_n = N_W'(MAX_WINDOW);
    end
  end

  assign req.n   = n_q;
  assign req.sy  = sy_q;
  assign req.sxy = sxy_q;
  assign req.syy = syy_q;

  srse_ring #(.DEPTH(MAX_WINDOW), .AW(AW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (wp_q),
    .wdata_i (y_q),
    .re_i    (accept),
    .raddr_i (old_idx),
    .rdata_o (rdata)
  );

  srse_solver u_solver (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= WINDOW_RESET;
      fill_q      <= '0;
      wp_q        <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      syy_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_i.valid) begin
            n_q    <= cfg_n;
            wp_q   <= '0;
            fill_q <= '0;
            sy_q   <= '0;
            sxy_q  <= '0;
            syy_q  <= '0;
          end else if (accept) begin
            y_q    <= in_i.sample;
            yy_q   <= in_i.sample * in_i.sample;
            ym_q   <= $signed({1'b0, weight}) * in_i.sample;
            full_q <= !in_i.restart && (fill_q >= n_q);
            if (in_i.restart) begin
              wp_q   <= '0;
              fill_q <= '0;
              sy_q   <= '0;
              sxy_q  <= '0;
              syy_q  <= '0;
            end
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (full_q) begin
            sy_q  <= sy_q - SY_W'(rdata) + SY_W'(y_q);
            sxy_q <= sxy_q - (SXY_W'(sy_q) - SXY_W'(rdata)) + SXY_W'(ym_q);
            syy_q <= syy_q - SYY_W'(oo) + SYY_W'(yy_q);
          end else begin
            sy_q   <= sy_q + SY_W'(y_q);
            sxy_q  <= sxy_q + SXY_W'(ym_q);
            syy_q  <= syy_q + SYY_W'(yy_q);
            fill_q <= fill_inc;
          end
          wp_q    <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
          state_q <= emit ? S_START : S_IDLE;
        end
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= rsp.result;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/srse_checker.sv =====
module srse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while previous one in work");

endmodule

bind sliding_regression_std_error_core srse_checker u_srse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.std_err)
);

// ===== dv/srse_std_error_monitor.sv =====
`timescale 1ns / 1ps

module srse_std_error_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  srse_in_if   in_i,
  srse_out_if  out_i,
  srse_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  import srse_pkg::*;

  logic signed [SAMPLE_W-1:0] window_ring [256];
  logic [7:0]                 wr_ptr;
  int unsigned                fill;
  int unsigned                span;
  longint                     sum_y;
  longint                     sum_xy;
  longint                     sum_yy;
  logic [RES_W-1:0]           expected_errors [$];

  assign pending_o = expected_errors.size();

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 64'd0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [RES_W-1:0] std_error(int unsigned n, longint sy, longint sxy,
                                                 longint syy);
    logic signed [127:0] wn, wsy, wsxy, wsyy, a, t, num, nn1;
    logic [127:0] q;
    logic [63:0] r;
    wn = 128'(n);
    wsy = 128'(sy);
    wsxy = 128'(sxy);
    wsyy = 128'(syy);
    nn1 = wn * wn - 128'sd1;
    a = wn * wsyy - wsy * wsy;
    t = 128'sd2 * wsxy - (wn - 128'sd1) * wsy;
    num = nn1 * a - 128'sd3 * t * t;
    if (num < 0) return '0;
    q = (128'(num) << 16) / 128'(wn * wn * nn1);
    if (q[127:64] != 64'd0) return '1;
    r = int_root(q[63:0]);
    if (r[63:32] != 32'd0) return '1;
    return r[31:0];
  endfunction

  task automatic clear_window();
    wr_ptr = '0;
    fill = 0;
    sum_y = 0;
    sum_xy = 0;
    sum_yy = 0;
  endtask

  task automatic take_sample(logic signed [SAMPLE_W-1:0] s, logic rs);
    longint y, old;
    y = longint'(s);
    if (rs) clear_window();
    if (fill >= span) begin
      old = longint'(window_ring[8'(wr_ptr - 8'(span))]);
      sum_xy = sum_xy - (sum_y - old);
      sum_y = sum_y - old;
      sum_yy = sum_yy - old * old;
      sum_xy = sum_xy + longint'(span - 1) * y;
    end else begin
      sum_xy = sum_xy + longint'(fill) * y;
      fill++;
    end
    sum_y = sum_y + y;
    sum_yy = sum_yy + y * y;
    window_ring[wr_ptr] = s;
    wr_ptr = wr_ptr + 8'd1;
    if (fill >= span) expected_errors.push_back(std_error(span, sum_y, sum_xy, sum_yy));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [RES_W-1:0] exp_v;
    if (!rst_ni) begin
      span = 32'(WINDOW_RESET);
      clear_window();
      expected_errors.delete();
      fail_count_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (expected_errors.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected beat: got %0h", out_i.std_err);
          fail_count_o++;
        end else begin
          exp_v = expected_errors.pop_front();
          if (exp_v !== out_i.std_err) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %0h got %0h", exp_v, out_i.std_err);
            fail_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        span = 32'(cfg_i.window_length);
        if (span < 2) span = 2;
        if (span > 256) span = 256;
        clear_window();
      end
      if (in_i.valid && in_i.ready) take_sample(in_i.sample, in_i.restart);
    end
  end

endmodule

// ===== dv/sliding_regression_std_error_core_test.sv =====
`timescale 1ns / 1ps

module sliding_regression_std_error_core_test;
  import srse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   span_now;
  int   out_beats;
  logic signed [SAMPLE_W-1:0] line_val;
  logic signed [SAMPLE_W-1:0] line_slope;

  srse_in_if  in_b ();
  srse_out_if out_b ();
  srse_cfg_if cfg_b ();

  sliding_regression_std_error_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_b),
    .out_o  (out_b),
    .cfg_i  (cfg_b)
  );

  srse_std_error_monitor u_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_b),
    .out_i        (out_b),
    .cfg_i        (cfg_b),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic rs);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_b.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_b.valid <= 1'b1;
    in_b.sample <= s;
    in_b.restart <= rs;
    do @(negedge clk_i); while (!in_b.ready);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_b.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_window(logic [N_W-1:0] v);
    cfg_b.valid <= 1'b1;
    cfg_b.window_length <= v;
    do @(negedge clk_i); while (!cfg_b.ready);
    @(posedge clk_i);
    cfg_b.valid <= 1'b0;
    span_now = (v < 2) ? 2 : (v > 256) ? 256 : int'(v);
  endtask

  task automatic random_run(int count);
    logic signed [SAMPLE_W-1:0] s;
    logic rs;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: s = SAMPLE_W'($urandom);
        6: begin
          case ($urandom_range(0, 3))
            0: s = 24'sh7FFFFF;
            1: s = 24'sh800000;
            2: s = '0;
            default: s = '1;
          endcase
        end
        7, 8: begin
          if ($urandom_range(0, 15) == 0) begin
            line_val = SAMPLE_W'($urandom);
            line_slope = $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
          end
          line_val = line_val + line_slope;
          s = line_val;
        end
        default: s = $signed(24'($urandom_range(0, 16))) - 24'sd8;
      endcase
      rs = (span_now <= 32) ? ($urandom_range(0, 39) == 0) : ($urandom_range(0, 399) == 0);
      send_sample(s, rs);
    end
  endtask

  initial begin
    logic [N_W-1:0] windows [9];
    int counts [9];
    windows = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd1, 9'd3, 9'd100, 9'd20, 9'd255};
    counts = '{100, 280, 100, 280, 100, 100, 100, 100, 100};
    in_b.valid = 1'b0;
    in_b.sample = '0;
    in_b.restart = 1'b0;
    cfg_b.valid = 1'b0;
    cfg_b.window_length = '0;
    span_now = int'(WINDOW_RESET);
    line_val = '0;
    line_slope = 24'sd3;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // window of 20 out of reset: flat line, extremes, restart mid-window
    for (int i = 0; i < 20; i++) send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh000000, 1'b0);
    send_sample(-24'sd1, 1'b0);
    random_run(40);
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_window(p == 8 ? 9'($urandom_range(0, 511)) : windows[p]);
      if (p == 8) begin
        @(posedge clk_i);
        write_window(windows[p]);
      end
      random_run(counts[p]);
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int gap;
    out_b.ready = 1'b0;
    out_beats = 0;
    forever begin
      gap = draw_gap();
      if (out_beats == 30) gap = 3000;
      if (gap > 0) begin
        out_b.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_b.ready <= 1'b1;
      do @(negedge clk_i); while (!out_b.valid);
      @(posedge clk_i);
      out_beats++;
    end
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/srse_pkg.sv
rtl/core/srse_if.sv
rtl/core/srse_ring.sv
rtl/core/srse_solver.sv
rtl/core/sliding_regression_std_error_core.sv
rtl/core/srse_checker.sv
dv/srse_std_error_monitor.sv
dv/sliding_regression_std_error_core_test.sv
